// ----- rtl/cfla_pkg.sv -----
// ----------------------------------------------------------------------------
// cfla_pkg
// Shared types and constants of the chunked free list allocator.
// ----------------------------------------------------------------------------
package cfla_pkg;

  // pool geometry
  localparam int MAX_CHUNKS = 4;
  localparam int MAX_BLOCKS = 64;

  localparam int CHUNK_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int BLK_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int OPEN_W  = $clog2(MAX_CHUNKS + 1);
  localparam int K_W     = (BLK_W > 1) ? $clog2(BLK_W) : 1;
  localparam int MEM_AW  = CHUNK_W + BLK_W;

  // field widths
  localparam int OFF_W   = 16;
  localparam int BSZ_W   = 8;
  localparam int NBLK_W  = 7;
  localparam int AVAIL_W = 7;
  localparam int IDX_W   = 8;
  localparam int ST_W    = 2;

  localparam logic [AVAIL_W-1:0] AVAIL_SAT = '1;

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_OOM      = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_FREE = 2'd2;

  // register indexes
  localparam logic REG_BLOCK_SIZE       = 1'b0;
  localparam logic REG_BLOCKS_PER_CHUNK = 1'b1;

  // shared arithmetic unit request and response
  typedef struct packed {
    logic [IDX_W-1:0] mul_a;
    logic [BSZ_W-1:0] mul_b;
    logic [OFF_W-1:0] sub_a;
    logic [OFF_W-1:0] sub_b;
  } alu_req_t;

  typedef struct packed {
    logic [OFF_W-1:0] prod;
    logic [OFF_W-1:0] diff;
    logic             ge;
  } alu_rsp_t;

endpackage

// ----- rtl/cfla_alu.sv -----
// ----------------------------------------------------------------------------
// cfla_alu
// Shared multiply and compare-subtract unit used by the sequencer.
// ----------------------------------------------------------------------------
module cfla_alu (
  input  cfla_pkg::alu_req_t req,
  output cfla_pkg::alu_rsp_t rsp
);

  logic [cfla_pkg::OFF_W:0] sub_full;

  // 8x8 product, operands widened so the full product fits the offset width
  assign rsp.prod = cfla_pkg::OFF_W'(req.mul_a) * cfla_pkg::OFF_W'(req.mul_b);

  // subtract with borrow out as the compare result
  assign sub_full = {1'b0, req.sub_a} - {1'b0, req.sub_b};
  assign rsp.diff = sub_full[cfla_pkg::OFF_W-1:0];
  assign rsp.ge   = ~sub_full[cfla_pkg::OFF_W];

endmodule

// ----- rtl/chunked_free_list_allocator_top.sv -----
// Allocate: check the current chunk, read and pop its list head, then scale the
//   block index to an offset; a full chunk first needs a scan and maybe a new list.
// Free: span multiply, then the chunk subtract loop and the 6-step block divide;
//   an offset past the open chunks ends right after the subtract loop.
// One request at a time; the list memory has one write and one registered read port.
// Synchronous active-low reset clears chunk heads, counts and the current chunk;
//   the list memory is not cleared and needs no startup pass.
// ----------------------------------------------------------------------------
// chunked_free_list_allocator_top
// Fixed-size block pool with an embedded free list per chunk, APB registers
// and stream request and result channels.
// ----------------------------------------------------------------------------
module chunked_free_list_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] free_offset
  input  logic [0:0]  in_tuser,    // [0] req_type
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] block_offset
  output logic [1:0]  out_tuser,   // [1:0] status
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_CHECK  = 12'b0000_0000_0010,
    S_SEARCH = 12'b0000_0000_0100,
    S_FILL   = 12'b0000_0000_1000,
    S_POP_RD = 12'b0000_0001_0000,
    S_POP    = 12'b0000_0010_0000,
    S_SCALE  = 12'b0000_0100_0000,
    S_SPAN   = 12'b0000_1000_0000,
    S_CDIV   = 12'b0001_0000_0000,
    S_BDIV   = 12'b0010_0000_0000,
    S_PUSH   = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_t;

  state_t state_r;

  // configuration registers
  logic [cfla_pkg::BSZ_W-1:0]   bs_r;
  logic [cfla_pkg::NBLK_W-1:0]  nblk_r;
  logic [cfla_pkg::BSZ_W-1:0]   bs_eff;
  logic [cfla_pkg::NBLK_W-1:0]  n_eff;

  // chunk bookkeeping
  logic [cfla_pkg::BLK_W-1:0]   head_r  [cfla_pkg::MAX_CHUNKS];
  logic [cfla_pkg::AVAIL_W-1:0] avail_r [cfla_pkg::MAX_CHUNKS];
  logic [cfla_pkg::OPEN_W-1:0]  chunks_open_r;
  logic [cfla_pkg::CHUNK_W-1:0] cur_r;
  logic                         cur_valid_r;

  // sequencer working registers
  logic [cfla_pkg::CHUNK_W-1:0] s_r;
  logic [cfla_pkg::CHUNK_W-1:0] c_r;
  logic [cfla_pkg::BLK_W-1:0]   fill_i_r;
  logic [cfla_pkg::BLK_W-1:0]   blk_r;
  logic [cfla_pkg::BLK_W-1:0]   q_r;
  logic [cfla_pkg::K_W-1:0]     k_r;
  logic [cfla_pkg::IDX_W-1:0]   idx_r;
  logic [cfla_pkg::OFF_W-1:0]   rem_r;
  logic [cfla_pkg::OFF_W-1:0]   span_r;
  logic [cfla_pkg::OFF_W-1:0]   res_off_r;
  logic [cfla_pkg::ST_W-1:0]    res_st_r;

  // output register
  logic                         out_tvalid_r;
  logic [cfla_pkg::OFF_W-1:0]   out_off_r;
  logic [cfla_pkg::ST_W-1:0]    out_st_r;

  // free list memory
  logic [cfla_pkg::BLK_W-1:0]   mem [2**cfla_pkg::MEM_AW];
  logic [cfla_pkg::BLK_W-1:0]   mem_rd_r;
  logic                         mem_we;
  logic [cfla_pkg::MEM_AW-1:0]  mem_waddr;
  logic [cfla_pkg::BLK_W-1:0]   mem_wdata;

  // chunk read select
  logic [cfla_pkg::CHUNK_W-1:0] sel_idx;
  logic [cfla_pkg::BLK_W-1:0]   sel_head;
  logic [cfla_pkg::AVAIL_W-1:0] sel_avail;

  logic s_last;
  logic fill_last;
  logic cfg_wr;

  cfla_pkg::alu_req_t alu_req;
  cfla_pkg::alu_rsp_t alu_rsp;

  cfla_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // effective register values
  assign bs_eff = (bs_r == '0) ? cfla_pkg::BSZ_W'(1) : bs_r;
  always_comb begin
    if (nblk_r == '0) begin
      n_eff = cfla_pkg::NBLK_W'(1);
    end else if (nblk_r > cfla_pkg::NBLK_W'(cfla_pkg::MAX_BLOCKS)) begin
      n_eff = cfla_pkg::NBLK_W'(cfla_pkg::MAX_BLOCKS);
    end else begin
      n_eff = nblk_r;
    end
  end

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r   <= cfla_pkg::BSZ_W'(16);
      nblk_r <= cfla_pkg::NBLK_W'(64);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        cfla_pkg::REG_BLOCK_SIZE:       bs_r   <= cfg_pwdata[cfla_pkg::BSZ_W-1:0];
        cfla_pkg::REG_BLOCKS_PER_CHUNK: nblk_r <= cfg_pwdata[cfla_pkg::NBLK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      cfla_pkg::REG_BLOCK_SIZE:       cfg_prdata = 32'(bs_r);
      cfla_pkg::REG_BLOCKS_PER_CHUNK: cfg_prdata = 32'(nblk_r);
      default:                        cfg_prdata = '0;
    endcase
  end

  // chunk entry read by the current step
  always_comb begin
    unique case (state_r)
      S_SEARCH:                 sel_idx = s_r;
      S_CDIV, S_BDIV, S_PUSH:   sel_idx = c_r;
      default:                  sel_idx = cur_r;
    endcase
  end
  assign sel_head  = head_r[sel_idx];
  assign sel_avail = avail_r[sel_idx];

  assign s_last    = (cfla_pkg::OPEN_W'(s_r) + cfla_pkg::OPEN_W'(1)) >= chunks_open_r;
  assign fill_last = (cfla_pkg::NBLK_W'(fill_i_r) + cfla_pkg::NBLK_W'(1)) == n_eff;

  // shared unit operand select
  always_comb begin
    alu_req.mul_a = cfla_pkg::IDX_W'(n_eff);
    alu_req.mul_b = bs_eff;
    alu_req.sub_a = rem_r;
    alu_req.sub_b = span_r;
    unique case (state_r)
      S_POP: begin
        alu_req.mul_a = cfla_pkg::IDX_W'(cur_r);
        alu_req.mul_b = cfla_pkg::BSZ_W'(n_eff);
      end
      S_SCALE: alu_req.mul_a = idx_r;
      S_BDIV:  alu_req.sub_b = cfla_pkg::OFF_W'(bs_eff) << k_r;
      default: ;
    endcase
  end

  // list memory write: chunk build or block push
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {c_r, q_r};
    mem_wdata = sel_head;
    if (state_r == S_FILL) begin
      mem_we    = 1'b1;
      mem_waddr = {cur_r, fill_i_r};
      mem_wdata = fill_last ? '0 : fill_i_r + cfla_pkg::BLK_W'(1);
    end else if (state_r == S_PUSH && rem_r == '0) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == S_POP_RD) begin
      mem_rd_r <= mem[{cur_r, sel_head}];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      chunks_open_r <= '0;
      cur_r         <= '0;
      cur_valid_r   <= 1'b0;
      out_tvalid_r  <= 1'b0;
      for (int i = 0; i < cfla_pkg::MAX_CHUNKS; i++) begin
        head_r[i]  <= '0;
        avail_r[i] <= '0;
      end
    end else begin
      // result taken downstream, unless a new one is loaded at this edge
      if (out_tready && state_r != S_DONE) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            rem_r   <= in_tdata;
            state_r <= (in_tuser[0] == cfla_pkg::REQ_FREE) ? S_SPAN : S_CHECK;
          end
        end

        // keep the current chunk while it has space
        S_CHECK: begin
          if (cur_valid_r && sel_avail != '0) begin
            state_r <= S_POP_RD;
          end else begin
            s_r     <= '0;
            state_r <= S_SEARCH;
          end
        end

        // scan open chunks in order, else open a new one, or report out of memory
        S_SEARCH: begin
          if (cfla_pkg::OPEN_W'(s_r) < chunks_open_r && sel_avail != '0) begin
            cur_r       <= s_r;
            cur_valid_r <= 1'b1;
            state_r     <= S_POP_RD;
          end else if (s_last) begin
            if (chunks_open_r == cfla_pkg::OPEN_W'(cfla_pkg::MAX_CHUNKS)) begin
              res_off_r <= '0;
              res_st_r  <= cfla_pkg::ST_OOM;
              state_r   <= S_DONE;
            end else begin
              cur_r       <= chunks_open_r[cfla_pkg::CHUNK_W-1:0];
              cur_valid_r <= 1'b1;
              fill_i_r    <= '0;
              state_r     <= S_FILL;
            end
          end else begin
            s_r <= s_r + cfla_pkg::CHUNK_W'(1);
          end
        end

        // build ascending list of the new chunk, one entry a cycle
        S_FILL: begin
          if (fill_last) begin
            head_r[cur_r]  <= '0;
            avail_r[cur_r] <= cfla_pkg::AVAIL_W'(n_eff);
            chunks_open_r  <= chunks_open_r + cfla_pkg::OPEN_W'(1);
            state_r        <= S_POP_RD;
          end else begin
            fill_i_r <= fill_i_r + cfla_pkg::BLK_W'(1);
          end
        end

        S_POP_RD: begin
          blk_r   <= sel_head;
          state_r <= S_POP;
        end

        // pop head, form block index
        S_POP: begin
          avail_r[cur_r] <= sel_avail - cfla_pkg::AVAIL_W'(1);
          head_r[cur_r]  <= mem_rd_r;
          idx_r          <= alu_rsp.prod[cfla_pkg::IDX_W-1:0] + cfla_pkg::IDX_W'(blk_r);
          state_r        <= S_SCALE;
        end

        S_SCALE: begin
          res_off_r <= alu_rsp.prod;
          res_st_r  <= cfla_pkg::ST_OK;
          state_r   <= S_DONE;
        end

        // chunk span for the free decode
        S_SPAN: begin
          span_r  <= alu_rsp.prod;
          c_r     <= '0;
          state_r <= S_CDIV;
        end

        // chunk number by repeated span subtraction
        S_CDIV: begin
          if (!alu_rsp.ge) begin
            if (cfla_pkg::OPEN_W'(c_r) >= chunks_open_r) begin
              res_off_r <= '0;
              res_st_r  <= cfla_pkg::ST_BAD_FREE;
              state_r   <= S_DONE;
            end else begin
              k_r     <= cfla_pkg::K_W'(cfla_pkg::BLK_W - 1);
              q_r     <= '0;
              state_r <= S_BDIV;
            end
          end else if ((cfla_pkg::OPEN_W'(c_r) + cfla_pkg::OPEN_W'(1)) >= chunks_open_r) begin
            res_off_r <= '0;
            res_st_r  <= cfla_pkg::ST_BAD_FREE;
            state_r   <= S_DONE;
          end else begin
            rem_r <= alu_rsp.diff;
            c_r   <= c_r + cfla_pkg::CHUNK_W'(1);
          end
        end

        // block number by restoring division, one quotient bit a cycle
        S_BDIV: begin
          if (alu_rsp.ge) begin
            rem_r    <= alu_rsp.diff;
            q_r[k_r] <= 1'b1;
          end
          if (k_r == '0) begin
            state_r <= S_PUSH;
          end else begin
            k_r <= k_r - cfla_pkg::K_W'(1);
          end
        end

        // misaligned offsets are rejected, else push the block
        S_PUSH: begin
          res_off_r <= '0;
          if (rem_r != '0) begin
            res_st_r <= cfla_pkg::ST_BAD_FREE;
          end else begin
            res_st_r    <= cfla_pkg::ST_OK;
            head_r[c_r] <= q_r;
            if (sel_avail != cfla_pkg::AVAIL_SAT) begin
              avail_r[c_r] <= sel_avail + cfla_pkg::AVAIL_W'(1);
            end
          end
          state_r <= S_DONE;
        end

        // hand the result to the output register
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_off_r    <= res_off_r;
            out_st_r     <= res_st_r;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_off_r;
  assign out_tuser  = out_st_r;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chunked free list allocator. Allocate and free
// requests go in on the stream input with random gaps, results are taken with
// random stalls, and each result is checked against its directed row or a pool
// model. Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIMIT_NS     = 5_000_000;
  localparam int RAND_ITEMS   = 1720;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_AT      = 600;   // results seen before the long receiver hold
  localparam int HOLD_CYCLES  = 400;
  localparam int FLOOD_LEN    = 130;   // enough repeated frees to saturate a count

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // one row of the directed sequence
  typedef struct packed {
    row_kind_t                  kind;
    logic                       sel;       // request kind or register index
    logic [cfla_pkg::OFF_W-1:0] arg;       // free offset or register value
    logic                       typed;     // expected result given in the row
    logic [cfla_pkg::OFF_W-1:0] want_off;
    logic [cfla_pkg::ST_W-1:0]  want_st;
  } stim_row_t;

  typedef struct packed {
    logic [cfla_pkg::OFF_W-1:0] off;
    logic [cfla_pkg::ST_W-1:0]  st;
  } pool_result_t;

  typedef struct packed {
    logic [cfla_pkg::CHUNK_W-1:0] chunk;
    logic [cfla_pkg::BLK_W-1:0]   blk;
  } block_pos_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  chunked_free_list_allocator_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // bench bookkeeping
  pool_result_t pending_results[$];
  block_pos_t   live_blocks[$];
  stim_row_t    dir_rows[$];
  pool_result_t head_want;
  int           err_cnt   = 0;
  int           n_results = 0;
  bit           idle_on   = 1'b0;

  // pool model state
  logic [cfla_pkg::BSZ_W-1:0]   cfg_bsize;
  logic [cfla_pkg::NBLK_W-1:0]  cfg_nblk;
  logic [cfla_pkg::BLK_W-1:0]   link_mem   [cfla_pkg::MAX_CHUNKS*cfla_pkg::MAX_BLOCKS];
  logic [cfla_pkg::BLK_W-1:0]   chunk_top  [cfla_pkg::MAX_CHUNKS];
  logic [cfla_pkg::AVAIL_W-1:0] chunk_left [cfla_pkg::MAX_CHUNKS];
  int                           open_cnt;
  int                           cur_chunk;
  bit                           cur_ok;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  function automatic int eff_bsize();
    return (cfg_bsize == 0) ? 1 : int'(cfg_bsize);
  endfunction

  function automatic int eff_nblk();
    if (cfg_nblk == 0) return 1;
    if (cfg_nblk > cfla_pkg::MAX_BLOCKS) return cfla_pkg::MAX_BLOCKS;
    return int'(cfg_nblk);
  endfunction

  function automatic logic [cfla_pkg::OFF_W-1:0] block_addr(input block_pos_t b);
    return cfla_pkg::OFF_W'((int'(b.chunk) * eff_nblk() + int'(b.blk)) * eff_bsize());
  endfunction

  // pool model: one request in, one result out, state updated in place
  function automatic void pool_predict(input logic req,
                                       input logic [cfla_pkg::OFF_W-1:0] addr,
                                       output pool_result_t res, output block_pos_t pos);
    int bs;
    int nb;
    int c;
    int blk;
    int span;
    int rem;
    bit found;
    bs  = eff_bsize();
    nb  = eff_nblk();
    res = '0;
    pos = '0;
    if (req == cfla_pkg::REQ_ALLOC) begin
      // current chunk empty or none yet: scan, then open a new chunk
      if (!cur_ok || chunk_left[cur_chunk] == 0) begin
        found = 1'b0;
        for (int i = 0; i < open_cnt; i++) begin
          if (!found && chunk_left[i] != 0) begin
            cur_chunk = i;
            cur_ok    = 1'b1;
            found     = 1'b1;
          end
        end
        if (!found) begin
          if (open_cnt >= cfla_pkg::MAX_CHUNKS) begin
            res.st = cfla_pkg::ST_OOM;
            return;
          end
          c = open_cnt;
          for (int i = 0; i < nb; i++)
            link_mem[c*cfla_pkg::MAX_BLOCKS + i] =
              cfla_pkg::BLK_W'((i + 1 == nb) ? 0 : i + 1);
          chunk_top[c]  = '0;
          chunk_left[c] = cfla_pkg::AVAIL_W'(nb);
          open_cnt++;
          cur_chunk = c;
          cur_ok    = 1'b1;
        end
      end
      // pop the head block
      c             = cur_chunk;
      blk           = int'(chunk_top[c]);
      chunk_left[c] = chunk_left[c] - 1'b1;
      chunk_top[c]  = link_mem[c*cfla_pkg::MAX_BLOCKS + blk];
      res.off       = cfla_pkg::OFF_W'((c * nb + blk) * bs);
      res.st        = cfla_pkg::ST_OK;
      pos.chunk     = cfla_pkg::CHUNK_W'(c);
      pos.blk       = cfla_pkg::BLK_W'(blk);
    end else begin
      // decode offset with the current register values, then push
      span = nb * bs;
      c    = int'(addr) / span;
      rem  = int'(addr) % span;
      if (c >= open_cnt || (rem % bs) != 0) begin
        res.st = cfla_pkg::ST_BAD_FREE;
        return;
      end
      blk                                    = rem / bs;
      link_mem[c*cfla_pkg::MAX_BLOCKS + blk] = chunk_top[c];
      chunk_top[c]                           = cfla_pkg::BLK_W'(blk);
      if (chunk_left[c] != cfla_pkg::AVAIL_SAT) chunk_left[c] = chunk_left[c] + 1'b1;
      res.st = cfla_pkg::ST_OK;
    end
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_row(input row_kind_t kind, input logic sel,
                                  input logic [cfla_pkg::OFF_W-1:0] arg,
                                  input logic typed,
                                  input logic [cfla_pkg::OFF_W-1:0] want_off,
                                  input logic [cfla_pkg::ST_W-1:0] want_st);
    stim_row_t row;
    row.kind     = kind;
    row.sel      = sel;
    row.arg      = arg;
    row.typed    = typed;
    row.want_off = want_off;
    row.want_st  = want_st;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // drive one request transaction, called and returning at a falling edge
  task automatic send_req(input logic req, input logic [cfla_pkg::OFF_W-1:0] addr,
                          input logic typed, input pool_result_t want);
    int           gap;
    pool_result_t got;
    block_pos_t   pos;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
    pool_predict(req, addr, got, pos);
    pending_results.insert(pending_results.size(), typed ? want : got);
    if (req == cfla_pkg::REQ_ALLOC && got.st == cfla_pkg::ST_OK)
      live_blocks.insert(live_blocks.size(), pos);
    @(negedge clk);
  endtask

  // drop valid and let every pending result drain
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write, then read back through a second transaction
  task automatic cfg_write(input logic idx, input logic [31:0] val);
    logic [31:0] got;
    logic [31:0] want;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == cfla_pkg::REG_BLOCK_SIZE) cfg_bsize = val[cfla_pkg::BSZ_W-1:0];
    else cfg_nblk = val[cfla_pkg::NBLK_W-1:0];
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    want = (idx == cfla_pkg::REG_BLOCK_SIZE) ? 32'(cfg_bsize) : 32'(cfg_nblk);
    if (got !== want) flag_mismatch("register read back", got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending", 32'({out_tuser, out_tdata}), 32'd0);
      end else begin
        head_want = pending_results.pop_front();
        if (out_tdata !== head_want.off)
          flag_mismatch("block_offset", 32'(out_tdata), 32'(head_want.off));
        if (out_tuser !== head_want.st)
          flag_mismatch("status", 32'(out_tuser), 32'(head_want.st));
      end
    end
  end

  // result receiver: random stalls plus one long hold while requests keep coming
  initial begin
    int stall;
    bit held;
    stall      = 0;
    held       = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && n_results >= HOLD_AT && in_tvalid) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // run limit
  initial begin
    #(LIMIT_NS);
    $display("** chunked_free_list_allocator_top: FAILED **");
    $finish;
  end

  // stimulus
  initial begin
    pool_result_t want;
    block_pos_t   pos;
    logic [cfla_pkg::OFF_W-1:0] addr;
    int n_rand;
    int n_items;
    int phase;
    int alloc_pct;
    int pick;
    int idx;
    int bs;
    int nb;

    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = cfla_pkg::REQ_ALLOC;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    rst_n       = 1'b0;
    cfg_bsize   = 8'd16;
    cfg_nblk    = 7'd64;
    open_cnt    = 0;
    cur_chunk   = 0;
    cur_ok      = 1'b0;
    for (int i = 0; i < cfla_pkg::MAX_CHUNKS; i++) begin
      chunk_top[i]  = '0;
      chunk_left[i] = '0;
    end
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed sequence
    // free with no chunk open yet
    add_row(ROW_REQ, cfla_pkg::REQ_FREE, 16'd0, 1'b1, 16'd0, cfla_pkg::ST_BAD_FREE);
    // zero block size acts as one, chunks of two blocks
    add_row(ROW_CFG, cfla_pkg::REG_BLOCK_SIZE, 16'd0, 1'b0, 16'd0, cfla_pkg::ST_OK);
    add_row(ROW_CFG, cfla_pkg::REG_BLOCKS_PER_CHUNK, 16'd2, 1'b0, 16'd0, cfla_pkg::ST_OK);
    // new chunk hands out blocks in ascending order
    add_row(ROW_REQ, cfla_pkg::REQ_ALLOC, 16'hFFFF, 1'b1, 16'd0, cfla_pkg::ST_OK);
    add_row(ROW_REQ, cfla_pkg::REQ_ALLOC, 16'h0000, 1'b1, 16'd1, cfla_pkg::ST_OK);
    add_row(ROW_REQ, cfla_pkg::REQ_ALLOC, 16'hA5A5, 1'b1, 16'd2, cfla_pkg::ST_OK);
    // free into chunk 0 leaves the current chunk alone
    add_row(ROW_REQ, cfla_pkg::REQ_FREE, 16'd0, 1'b1, 16'd0, cfla_pkg::ST_OK);
    add_row(ROW_REQ, cfla_pkg::REQ_ALLOC, 16'h0000, 1'b1, 16'd3, cfla_pkg::ST_OK);
    add_row(ROW_REQ, cfla_pkg::REQ_ALLOC, 16'h0000, 1'b1, 16'd0, cfla_pkg::ST_OK);
    // fill the pool
    add_row(ROW_REQ, cfla_pkg::REQ_ALLOC, 16'h0000, 1'b1, 16'd4, cfla_pkg::ST_OK);
    add_row(ROW_REQ, cfla_pkg::REQ_ALLOC, 16'h0000, 1'b1, 16'd5, cfla_pkg::ST_OK);
    add_row(ROW_REQ, cfla_pkg::REQ_ALLOC, 16'h0000, 1'b1, 16'd6, cfla_pkg::ST_OK);
    add_row(ROW_REQ, cfla_pkg::REQ_ALLOC, 16'h0000, 1'b1, 16'd7, cfla_pkg::ST_OK);
    add_row(ROW_REQ, cfla_pkg::REQ_ALLOC, 16'h0000, 1'b1, 16'd0, cfla_pkg::ST_OOM);
    // offset past the open chunks
    add_row(ROW_REQ, cfla_pkg::REQ_FREE, 16'd8, 1'b1, 16'd0, cfla_pkg::ST_BAD_FREE);
    // misaligned free, then a double free
    add_row(ROW_CFG, cfla_pkg::REG_BLOCK_SIZE, 16'd16, 1'b0, 16'd0, cfla_pkg::ST_OK);
    add_row(ROW_REQ, cfla_pkg::REQ_FREE, 16'd16, 1'b1, 16'd0, cfla_pkg::ST_OK);
    add_row(ROW_REQ, cfla_pkg::REQ_FREE, 16'd40, 1'b1, 16'd0, cfla_pkg::ST_BAD_FREE);
    add_row(ROW_REQ, cfla_pkg::REQ_FREE, 16'd16, 1'b1, 16'd0, cfla_pkg::ST_OK);
    add_row(ROW_REQ, cfla_pkg::REQ_ALLOC, 16'h0000, 1'b0, 16'd0, cfla_pkg::ST_OK);
    add_row(ROW_REQ, cfla_pkg::REQ_ALLOC, 16'h0000, 1'b0, 16'd0, cfla_pkg::ST_OK);
    // largest block size, chunk size above the bound
    add_row(ROW_CFG, cfla_pkg::REG_BLOCK_SIZE, 16'd255, 1'b0, 16'd0, cfla_pkg::ST_OK);
    add_row(ROW_CFG, cfla_pkg::REG_BLOCKS_PER_CHUNK, 16'd127, 1'b0, 16'd0, cfla_pkg::ST_OK);
    add_row(ROW_REQ, cfla_pkg::REQ_FREE, 16'd65025, 1'b1, 16'd0, cfla_pkg::ST_OK);
    add_row(ROW_REQ, cfla_pkg::REQ_FREE, 16'hFFFF, 1'b1, 16'd0, cfla_pkg::ST_BAD_FREE);
    add_row(ROW_REQ, cfla_pkg::REQ_ALLOC, 16'h0000, 1'b1, 16'd65025, cfla_pkg::ST_OK);
    add_row(ROW_REQ, cfla_pkg::REQ_FREE, 16'd255, 1'b1, 16'd0, cfla_pkg::ST_OK);
    add_row(ROW_REQ, cfla_pkg::REQ_FREE, 16'd256, 1'b1, 16'd0, cfla_pkg::ST_BAD_FREE);
    add_row(ROW_REQ, cfla_pkg::REQ_ALLOC, 16'h0000, 1'b0, 16'd0, cfla_pkg::ST_OK);
    // zero chunk size acts as one
    add_row(ROW_CFG, cfla_pkg::REG_BLOCKS_PER_CHUNK, 16'd0, 1'b0, 16'd0, cfla_pkg::ST_OK);
    add_row(ROW_REQ, cfla_pkg::REQ_FREE, 16'd510, 1'b0, 16'd0, cfla_pkg::ST_OK);
    add_row(ROW_REQ, cfla_pkg::REQ_ALLOC, 16'h0000, 1'b0, 16'd0, cfla_pkg::ST_OK);

    idle_on = 1'b1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(dir_rows[i].sel, 32'(dir_rows[i].arg));
      end else begin
        want.off = dir_rows[i].want_off;
        want.st  = dir_rows[i].want_st;
        send_req(dir_rows[i].sel, dir_rows[i].arg, dir_rows[i].typed, want);
      end
    end

    // random phases, each with its own register setting and traffic mix
    want   = '0;
    n_rand = 0;
    phase  = 0;
    while (n_rand < RAND_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 4))
        0:       bs = 0;
        1:       bs = 1;
        2:       bs = 255;
        default: bs = $urandom_range(1, 255);
      endcase
      case ($urandom_range(0, 5))
        0:       nb = 0;
        1:       nb = 1;
        2:       nb = cfla_pkg::MAX_BLOCKS;
        3:       nb = 127;
        4:       nb = $urandom_range(cfla_pkg::MAX_BLOCKS + 1, 126);
        default: nb = $urandom_range(2, 16);
      endcase
      cfg_write(cfla_pkg::REG_BLOCK_SIZE, 32'(bs));
      cfg_write(cfla_pkg::REG_BLOCKS_PER_CHUNK, 32'(nb));
      idle_on   = ($urandom_range(0, 3) != 0);
      alloc_pct = $urandom_range(25, 75);

      if (phase == 2) begin
        // repeated free of one block drives its chunk count to saturation
        pos = '0;
        repeat (FLOOD_LEN) send_req(cfla_pkg::REQ_FREE, block_addr(pos), 1'b0, want);
        repeat (FLOOD_LEN)
          send_req(cfla_pkg::REQ_ALLOC, cfla_pkg::OFF_W'($urandom), 1'b0, want);
        n_rand += 2 * FLOOD_LEN;
      end else begin
        n_items = $urandom_range(100, 200);
        if (n_items > RAND_ITEMS - n_rand) n_items = RAND_ITEMS - n_rand;
        repeat (n_items) begin
          pick = $urandom_range(0, 99);
          if (pick < alloc_pct) begin
            send_req(cfla_pkg::REQ_ALLOC, cfla_pkg::OFF_W'($urandom), 1'b0, want);
          end else begin
            pick = $urandom_range(0, 99);
            if (pick < 75 && live_blocks.size() > 0) begin
              // release a block that is still out
              idx = $urandom_range(0, live_blocks.size() - 1);
              pos = live_blocks[idx];
              live_blocks.delete(idx);
              addr = block_addr(pos);
            end else if (pick < 90) begin
              // any block position, may be a double free
              pos.chunk = cfla_pkg::CHUNK_W'($urandom);
              pos.blk   = cfla_pkg::BLK_W'($urandom_range(0, eff_nblk() - 1));
              addr = block_addr(pos);
            end else if (pick < 95) begin
              pos.chunk = cfla_pkg::CHUNK_W'($urandom);
              pos.blk   = cfla_pkg::BLK_W'($urandom_range(0, eff_nblk() - 1));
              addr = block_addr(pos) + 1'b1;
            end else begin
              addr = cfla_pkg::OFF_W'($urandom);
            end
            send_req(cfla_pkg::REQ_FREE, addr, 1'b0, want);
          end
        end
        n_rand += n_items;
      end
      phase++;
    end

    // drain and report
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("** chunked_free_list_allocator_top: PASSED **");
    end else begin
      $display("** chunked_free_list_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule
